// ===== rtl/core/longest_common_subsequence_length_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LCS length engine
// Shared concurrent-assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef LONGEST_COMMON_SUBSEQUENCE_LENGTH_MACROS_SVH
`define LONGEST_COMMON_SUBSEQUENCE_LENGTH_MACROS_SVH

// condition holds in the same cycle as the trigger
`define LCS_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define LCS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Types, codes and defaults shared by the LCS length engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  localparam int MAX_LEN_DEF     = 256;
  localparam int TOKEN_WIDTH_DEF = 32;

  localparam logic [1:0] CMD_APPEND_A = 2'd0;
  localparam logic [1:0] CMD_APPEND_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] token;
  } lcs_in_t;

  typedef struct packed {
    logic [8:0] lcs_length;
    logic       overflow;
  } lcs_out_t;

  // per-cell control from the sequencer to the DP row unit
  typedef struct packed {
    logic issue;
    logic row_start;
    logic first_row;
    logic last;
  } lcs_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lcs_tok_mem.sv =====
// ----------------------------------------------------------------------------
// lcs_tok_mem
// Token store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_tok_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcs_dp_row.sv =====
// ----------------------------------------------------------------------------
// lcs_dp_row
// One-row DP store with the match/max cell update, one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_dp_row #(
  parameter int MAX_LEN     = 256,
  parameter int TOKEN_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lcs_pkg::lcs_cell_ctrl_t       ctrl,
  input  wire logic [$clog2(MAX_LEN)-1:0]    rd_addr,
  input  wire logic [TOKEN_WIDTH-1:0]        a_tok,
  input  wire logic [TOKEN_WIDTH-1:0]        b_tok,
  output logic                               done,
  output logic      [$clog2(MAX_LEN+1)-1:0]  value
);
  import lcs_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0] mem [MAX_LEN];
  logic [LW-1:0] rd_q;

  logic           stg_valid;
  lcs_cell_ctrl_t stg;
  logic [AW-1:0]  stg_addr;
  logic           fwd;
  logic [LW-1:0]  fwd_val;
  logic [LW-1:0]  left_q;
  logic [LW-1:0]  diag_q;

  logic [LW-1:0] up;
  logic [LW-1:0] left;
  logic [LW-1:0] diag;
  logic [LW-1:0] score;

  // first row sees the zeroed row; a single-column row rereads the cell just written
  always_comb begin
    if (stg.first_row) begin
      up = '0;
    end else if (fwd) begin
      up = fwd_val;
    end else begin
      up = rd_q;
    end
    left = stg.row_start ? '0 : left_q;
    diag = stg.row_start ? '0 : diag_q;
    if (a_tok == b_tok) begin
      score = diag + LW'(1);
    end else begin
      score = (up > left) ? up : left;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      rd_q <= mem[rd_addr];
    end
    if (stg_valid) begin
      mem[stg_addr] <= score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      stg_valid <= ctrl.issue;
      fwd       <= ctrl.issue && stg_valid && (rd_addr == stg_addr);
    end
  end

  always_ff @(posedge clk) begin
    stg      <= ctrl;
    stg_addr <= rd_addr;
    fwd_val  <= score;
    if (stg_valid) begin
      left_q <= score;
      diag_q <= up;
    end
  end

  assign done  = stg_valid && stg.last;
  assign value = score;

endmodule

`default_nettype wire

// ===== rtl/core/longest_common_subsequence_length.sv =====
// ----------------------------------------------------------------------------
// longest_common_subsequence_length: LCS length engine over two token stores
// Appends: accepted one per cycle while idle, no result. Compute: the DP
// cells are swept one per cycle in RUN, then DRAIN and POST, which registers
// the result (straight to POST if a sequence is empty); input stalls until
// idle again, longer while an earlier result is still held by the receiver.
// Sync reset clears lengths, overflow and control; no memory clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "longest_common_subsequence_length_macros.svh"

module longest_common_subsequence_length #(
  parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
  parameter int TOKEN_WIDTH = lcs_pkg::TOKEN_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire lcs_pkg::lcs_in_t  item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output lcs_pkg::lcs_out_t      result
);
  import lcs_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_POST  = 2'd3;

  logic [1:0]    state;
  logic [LW-1:0] len_a;
  logic [LW-1:0] len_b;
  logic          ovf;
  logic [AW-1:0] i_idx;
  logic [AW-1:0] j_idx;
  logic [LW-1:0] res_len;

  logic                   accept;
  logic                   out_free;
  logic [63:0]            tok_ext;
  logic                   wr_a;
  logic                   wr_b;
  logic [AW-1:0]          last_a;
  logic [AW-1:0]          last_b;
  logic [LW-1:0]          len_a_m1;
  logic [LW-1:0]          len_b_m1;
  lcs_cell_ctrl_t         ctrl;
  logic [TOKEN_WIDTH-1:0] a_tok;
  logic [TOKEN_WIDTH-1:0] b_tok;
  logic                   eng_done;
  logic [LW-1:0]          eng_value;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign tok_ext    = 64'(item.token);

  assign wr_a = accept && (item.command == CMD_APPEND_A) && (len_a < LW'(MAX_LEN));
  assign wr_b = accept && (item.command == CMD_APPEND_B) && (len_b < LW'(MAX_LEN));

  assign len_a_m1 = len_a - LW'(1);
  assign len_b_m1 = len_b - LW'(1);
  assign last_a   = len_a_m1[AW-1:0];
  assign last_b   = len_b_m1[AW-1:0];

  always_comb begin
    ctrl.issue     = (state == S_RUN);
    ctrl.row_start = (j_idx == '0);
    ctrl.first_row = (i_idx == '0);
    ctrl.last      = (i_idx == last_a) && (j_idx == last_b);
  end

  lcs_tok_mem #(.DEPTH(MAX_LEN), .WIDTH(TOKEN_WIDTH)) u_seq_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (len_a[AW-1:0]),
    .wr_data (tok_ext[TOKEN_WIDTH-1:0]),
    .rd_addr (i_idx),
    .rd_data (a_tok)
  );

  lcs_tok_mem #(.DEPTH(MAX_LEN), .WIDTH(TOKEN_WIDTH)) u_seq_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (len_b[AW-1:0]),
    .wr_data (tok_ext[TOKEN_WIDTH-1:0]),
    .rd_addr (j_idx),
    .rd_data (b_tok)
  );

  lcs_dp_row #(.MAX_LEN(MAX_LEN), .TOKEN_WIDTH(TOKEN_WIDTH)) u_dp_row (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_addr (j_idx),
    .a_tok   (a_tok),
    .b_tok   (b_tok),
    .done    (eng_done),
    .value   (eng_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      len_a        <= '0;
      len_b        <= '0;
      ovf          <= 1'b0;
      i_idx        <= '0;
      j_idx        <= '0;
      result_valid <= 1'b0;
    end else begin
      // output register frees up or takes the new result
      if (out_free) begin
        result_valid <= (state == S_POST);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.command == CMD_APPEND_A) begin
              if (wr_a) begin
                len_a <= len_a + LW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end else if (item.command == CMD_APPEND_B) begin
              if (wr_b) begin
                len_b <= len_b + LW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end else if (item.command == CMD_COMPUTE) begin
              i_idx <= '0;
              j_idx <= '0;
              if ((len_a == '0) || (len_b == '0)) begin
                state <= S_POST;
              end else begin
                state <= S_RUN;
              end
            end
          end
        end
        S_RUN: begin
          if (j_idx == last_b) begin
            j_idx <= '0;
            if (i_idx == last_a) begin
              state <= S_DRAIN;
            end else begin
              i_idx <= i_idx + AW'(1);
            end
          end else begin
            j_idx <= j_idx + AW'(1);
          end
        end
        S_DRAIN: begin
          if (eng_done) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (out_free) begin
            len_a <= '0;
            len_b <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload; empty sequences give zero
  always_ff @(posedge clk) begin
    if (accept && (item.command == CMD_COMPUTE)) begin
      res_len <= '0;
    end else if ((state == S_DRAIN) && eng_done) begin
      res_len <= eng_value;
    end
    if ((state == S_POST) && out_free) begin
      result.lcs_length <= 9'(res_len);
      result.overflow   <= ovf;
    end
  end

  `LCS_ASSERT_SAME(a_done_in_drain, clk, rst, eng_done, state == S_DRAIN,
                   "DP result arrived outside drain")
  `LCS_ASSERT_SAME(a_run_nonempty, clk, rst, state == S_RUN,
                   (len_a != '0) && (len_b != '0), "cell sweep over an empty sequence")
  `LCS_ASSERT_NEXT(a_load_from_post, clk, rst, state != S_POST, !$rose(result_valid),
                   "result raised outside the post state")

endmodule

`default_nettype wire
